### rtl/wall_follow_steering_unit_macros.svh
// Assertion macros for the wall following steering unit.
`ifndef WALL_FOLLOW_STEERING_UNIT_MACROS_SVH
`define WALL_FOLLOW_STEERING_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define WFS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WFS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WFS_ASSERT(label, clk, rst_n, prop, msg)
`define WFS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### rtl/wfs_pkg.sv
package wfs_pkg;

  // Number of entries in the arctangent table; steps beyond it are not run.
  localparam int unsigned TabLen = 20;

  // Width of the CORDIC datapath words.
  localparam int unsigned CordW = 34;
  localparam int unsigned AngW  = 32;

  localparam logic signed [CordW-1:0] InvGainQ30 = 34'sd652032874;
  localparam logic [16:0] FwdOne   = 17'd65536;
  localparam logic [16:0] FwdFifth = 17'd13107;

  typedef enum logic [1:0] {
    MODE_STEEP    = 2'd0,
    MODE_FAR      = 2'd1,
    MODE_TRACKING = 2'd2
  } drive_mode_e;

  typedef enum logic [2:0] {
    REG_SPACING   = 3'd0,
    REG_MAX_ANGLE = 3'd1,
    REG_TARGET    = 3'd2,
    REG_DIST_GAIN = 3'd3,
    REG_ANG_GAIN  = 3'd4,
    REG_SPEED     = 3'd5,
    REG_NEAR_BAND = 3'd6
  } reg_index_e;

  // Per-cell CORDIC state handed from one cell to the next.
  typedef struct packed {
    logic signed [CordW-1:0] vx;
    logic signed [CordW-1:0] vy;
    logic signed [AngW-1:0]  vz;
    logic signed [CordW-1:0] rx;
    logic signed [CordW-1:0] ry;
    logic signed [AngW-1:0]  rz;
    logic [16:0]             dsum;
  } cord_t;

  // Arctangent table, Q30 radians.
  function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [AngW-1:0] r;
    begin
      case (idx)
        5'd0: r = 32'sd843314857;
        5'd1: r = 32'sd497837829;
        5'd2: r = 32'sd263043837;
        5'd3: r = 32'sd133525159;
        5'd4: r = 32'sd67021687;
        5'd5: r = 32'sd33543516;
        5'd6: r = 32'sd16775851;
        5'd7: r = 32'sd8388437;
        5'd8: r = 32'sd4194283;
        5'd9: r = 32'sd2097149;
        5'd10: r = 32'sd1048576;
        5'd11: r = 32'sd524288;
        5'd12: r = 32'sd262144;
        5'd13: r = 32'sd131072;
        5'd14: r = 32'sd65536;
        5'd15: r = 32'sd32768;
        5'd16: r = 32'sd16384;
        5'd17: r = 32'sd8192;
        5'd18: r = 32'sd4096;
        5'd19: r = 32'sd2048;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/wfs_cordic_cell.sv
// One CORDIC cell: a vectoring step and a rotation step on the same item.
// The rotation cell at this position uses the angle the vectoring pass
// produced once all vectoring steps are done, so the rotation chain lags.
module wfs_cordic_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  wfs_pkg::cord_t cell_i,
  output wfs_pkg::cord_t cell_o
);
  import wfs_pkg::*;

  cord_t cell_d, cell_q;
  logic signed [AngW-1:0] atan_w;

  assign atan_w = atan_q30(5'(Shift));

  // Micro-rotation on both vector pairs.
  always_comb begin
    cell_d = cell_i;
    if (cell_i.vy >= 0) begin
      cell_d.vx = cell_i.vx + (cell_i.vy >>> Shift);
      cell_d.vy = cell_i.vy - (cell_i.vx >>> Shift);
      cell_d.vz = cell_i.vz + atan_w;
    end else begin
      cell_d.vx = cell_i.vx - (cell_i.vy >>> Shift);
      cell_d.vy = cell_i.vy + (cell_i.vx >>> Shift);
      cell_d.vz = cell_i.vz - atan_w;
    end
    if (cell_i.rz >= 0) begin
      cell_d.rx = cell_i.rx - (cell_i.ry >>> Shift);
      cell_d.ry = cell_i.ry + (cell_i.rx >>> Shift);
      cell_d.rz = cell_i.rz - atan_w;
    end else begin
      cell_d.rx = cell_i.rx + (cell_i.ry >>> Shift);
      cell_d.ry = cell_i.ry - (cell_i.rx >>> Shift);
      cell_d.rz = cell_i.rz + atan_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule

### rtl/wfs_post.sv
// Gating and wheel mixing, five pipeline stages after the CORDIC chains.
module wfs_post (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [31:0]   z_i,
  input  logic signed [33:0]   cos_i,
  input  logic [16:0]          dsum_i,
  input  logic [13:0]          max_angle_i,
  input  logic [15:0]          target_i,
  input  logic [15:0]          dgain_i,
  input  logic [15:0]          again_i,
  input  logic [14:0]          speed_i,
  input  logic [15:0]          band_i,
  output logic signed [15:0]   right_o,
  output logic signed [15:0]   left_o,
  output logic [1:0]           mode_o
);
  import wfs_pkg::*;

  // Stage A: angle, cosine, distance product.
  logic signed [31:0] zr;
  logic signed [33:0] cr;
  logic signed [15:0] theta_d, theta_q;
  logic [15:0] cos_d;
  logic [32:0] prod_d, prod_q;

  always_comb begin
    zr = z_i + 32'sd65536;
    theta_d = -16'(zr >>> 17);
    cr = (cos_i + 34'sd65536) >>> 17;
    cos_d = cr[33] ? 16'd0 : cr[15:0];
    prod_d = 33'(dsum_i) * 33'(cos_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      theta_q <= theta_d;
      prod_q <= prod_d;
    end
  end

  // Stage B: distance, error and gating.
  logic [33:0] dr;
  logic [16:0] wall_dist;
  logic signed [17:0] err_d, err_q, abs_err;
  logic [15:0] abs_theta;
  logic [16:0] fwd_d, fwd_q;
  logic turn_d, turn_q;
  logic [1:0] mode_d, mode_q1, mode_q2;
  logic signed [15:0] theta_q2;

  always_comb begin
    dr = (34'(prod_q) + 34'd8192) >> 14;
    wall_dist = (dr > 34'd65535) ? 17'd65535 : dr[16:0];
    err_d = 18'(signed'({1'b0, wall_dist})) - 18'(signed'({2'b00, target_i}));
    abs_err = err_d[17] ? -err_d : err_d;
    abs_theta = theta_q[15] ? 16'(-theta_q) : 16'(theta_q);
    if (abs_theta > {2'b00, max_angle_i}) begin
      fwd_d = FwdFifth; turn_d = 1'b1; mode_d = MODE_STEEP;
    end else if (abs_err > 18'(signed'({2'b00, band_i}))) begin
      fwd_d = FwdOne; turn_d = 1'b0; mode_d = MODE_FAR;
    end else begin
      fwd_d = FwdOne; turn_d = 1'b1; mode_d = MODE_TRACKING;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err_q <= err_d;
      fwd_q <= fwd_d;
      turn_q <= turn_d;
      mode_q1 <= mode_d;
      theta_q2 <= theta_q;
    end
  end

  // Stage C: gain products (Q20 err*Kd, Q25 theta*Ka, Q8 speed).
  logic signed [34:0] kd_d, kd_q;
  logic signed [32:0] ka_d, ka_q;
  logic [16:0] fwd_q2;
  logic [14:0] spd_q;

  always_comb begin
    kd_d = 35'(err_q) * 35'(signed'({1'b0, dgain_i}));
    ka_d = turn_q ? 33'(theta_q2) * 33'(signed'({1'b0, again_i})) : 33'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kd_q <= kd_d;
      ka_q <= ka_d;
      fwd_q2 <= fwd_q;
      spd_q <= speed_i;
      mode_q2 <= mode_q1;
    end
  end

  // Stage D: forward scaling products.
  logic signed [52:0] kdf_d, kdf_q;
  logic signed [52:0] vf_d, vf_q;
  logic signed [52:0] ka36_q;
  logic [1:0] mode_q3;

  always_comb begin
    kdf_d = 53'(kd_q) * 53'(signed'({1'b0, fwd_q2}));
    vf_d = 53'(signed'({1'b0, spd_q})) * 53'(signed'({1'b0, fwd_q2}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kdf_q <= kdf_d;
      vf_q <= vf_d <<< 12;
      ka36_q <= 53'(ka_q) <<< 11;
      mode_q3 <= mode_q2;
    end
  end

  // Stage E: mix, round and saturate.
  logic signed [54:0] w, rsum, lsum;
  logic signed [54:0] rr, lr;
  logic signed [15:0] right_d, left_d;

  function automatic logic signed [15:0] sat16(input logic signed [54:0] v);
    begin
      if (v > 55'sd32767) return 16'sh7fff;
      else if (v < -55'sd32768) return 16'sh8000;
      else return v[15:0];
    end
  endfunction

  always_comb begin
    w = 55'(kdf_q) - 55'(ka36_q);
    rsum = w - 55'(vf_q);
    lsum = -55'(vf_q) - w;
    rr = (rsum + 55'sd134217728) >>> 28;
    lr = (lsum + 55'sd134217728) >>> 28;
    right_d = sat16(rr);
    left_d = sat16(lr);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      right_o <= right_d;
      left_o <= left_d;
      mode_o <= mode_q3;
    end
  end
endmodule

### rtl/wall_follow_steering_unit.sv
// Wall following steering unit. One sensor pair is accepted per clock while
// the output is not stalled, and gives one wheel command item. An item passes
// 2*CORDIC_STEPS + 5 register stages (CORDIC_STEPS taken at no more than 20):
// a chain of CORDIC_STEPS vectoring cells finds the wall angle, then a second
// chain of CORDIC_STEPS rotation cells finds its cosine, followed by four
// arithmetic stages and the output register. The whole pipeline advances
// unless the output holds an item that is stalled; in_stall_o is high in
// exactly those cycles, so the input is held off while the output stalls.
// Configuration must be written by the user only while the pipeline holds no
// item; the block itself does not enforce this.
module wall_follow_steering_unit #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         front_dist_i,
  input  logic [15:0]         rear_dist_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  right_wheel_o,
  output logic signed [15:0]  left_wheel_o,
  output logic [1:0]          drive_mode_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import wfs_pkg::*;
  `include "wall_follow_steering_unit_macros.svh"

  localparam int unsigned Steps = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;
  localparam int unsigned Depth = 2 * Steps + 5;

  // Configuration registers.
  logic [15:0] spacing_q, target_q, dgain_q, again_q, band_q;
  logic [13:0] max_angle_q;
  logic [14:0] speed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= 16'd5120;
      max_angle_q <= 14'd2458;
      target_q <= 16'd3840;
      dgain_q <= 16'd410;
      again_q <= 16'd4096;
      speed_q <= 15'd2560;
      band_q <= 16'd1280;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SPACING:   spacing_q <= cfg_data_i;
        REG_MAX_ANGLE: max_angle_q <= cfg_data_i[13:0];
        REG_TARGET:    target_q <= cfg_data_i;
        REG_DIST_GAIN: dgain_q <= cfg_data_i;
        REG_ANG_GAIN:  again_q <= cfg_data_i;
        REG_SPEED:     speed_q <= cfg_data_i[14:0];
        REG_NEAR_BAND: band_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline enable and valid tracking.
  logic en;
  logic [Depth-1:0] vld_q;

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Vectoring chain.
  cord_t vec_c [Steps+1];
  cord_t rot_c [Steps+1];

  always_comb begin
    vec_c[0].vx = CordW'(signed'({1'b0, spacing_q})) <<< 12;
    vec_c[0].vy = (CordW'(signed'({1'b0, front_dist_i}))
                   - CordW'(signed'({1'b0, rear_dist_i}))) <<< 12;
    vec_c[0].vz = '0;
    vec_c[0].rx = '0;
    vec_c[0].ry = '0;
    vec_c[0].rz = '0;
    vec_c[0].dsum = 17'(front_dist_i) + 17'(rear_dist_i);
  end

  for (genvar g = 0; g < Steps; g++) begin : g_vec
    wfs_cordic_cell #(.Shift(g)) u_cell (
      .clk_i(clk_i), .en_i(en), .cell_i(vec_c[g]), .cell_o(vec_c[g+1]));
  end

  // Rotation chain seeded with the finished angle.
  always_comb begin
    rot_c[0] = vec_c[Steps];
    rot_c[0].vx = '0;
    rot_c[0].vy = '0;
    rot_c[0].rx = InvGainQ30;
    rot_c[0].ry = '0;
    rot_c[0].rz = vec_c[Steps].vz;
  end

  // The rotation cells also carry the final angle in vz.
  cord_t rot_in [Steps];
  for (genvar g = 0; g < Steps; g++) begin : g_rot
    cord_t hold_q;
    always_comb begin
      rot_in[g] = rot_c[g];
      rot_in[g].vy = -34'sd1;
    end
    wfs_cordic_cell #(.Shift(g)) u_cell (
      .clk_i(clk_i), .en_i(en), .cell_i(rot_in[g]), .cell_o(hold_q));
    always_comb begin
      rot_c[g+1] = hold_q;
      rot_c[g+1].vz = hold_q.vz + atan_q30(5'(g));
    end
  end

  wfs_post u_post (
    .clk_i(clk_i), .en_i(en),
    .z_i(rot_c[Steps].vz), .cos_i(rot_c[Steps].rx), .dsum_i(rot_c[Steps].dsum),
    .max_angle_i(max_angle_q), .target_i(target_q), .dgain_i(dgain_q),
    .again_i(again_q), .speed_i(speed_q), .band_i(band_q),
    .right_o(right_wheel_o), .left_o(left_wheel_o), .mode_o(drive_mode_o));

  `WFS_ASSERT(a_stall_holds_out, clk_i, rst_ni,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(right_wheel_o),
              "stalled item changed")
  `WFS_ASSERT(a_mode_legal, clk_i, rst_ni, out_valid_o |-> drive_mode_o != 2'd3, "bad mode")
  `WFS_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o, "valid in reset")
endmodule
